// ===== rtl/aocm_pkg.sv =====
// shared types, constants and calibration tables for the auto-ranging meter
package aocm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;

    localparam int FLOOR_W    = 23;
    localparam int CH_W       = 3;
    localparam int RANGE_W    = 2;
    localparam int IN_USER_W  = CH_W;
    localparam int OUT_USER_W = CH_W + RANGE_W + 1 + CH_W;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int FRAC_SHIFT = 24;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

    localparam int RECIP_W = 22;
    localparam logic [RECIP_W-1:0] RECIP_R2 = RECIP_W'(3744914);
    localparam logic [RECIP_W-1:0] RECIP_R3 = RECIP_W'(372827);

    localparam int KINK_W  = 21;
    localparam int KINK_AT = 1303358;

    localparam int COEF_W = 28;
    localparam int OFFS_W = 21;

    localparam logic [RANGE_W-1:0] RANGE_X1  = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_X4  = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_X45 = 2'd3;

    localparam logic [CH_W-1:0] CH_LAST    = 3'd3;
    localparam logic [CH_W-1:0] CH_CLEARED = 3'd4;

    localparam logic [1:0] REG_RANGE_ONE_FLOOR = 2'd0;
    localparam logic [1:0] REG_RANGE_TWO_FLOOR = 2'd1;
    localparam logic [1:0] REG_ZERO_FLOOR      = 2'd2;

    localparam logic [FLOOR_W-1:0] RANGE_ONE_FLOOR_RST = FLOOR_W'(262144);
    localparam logic [FLOOR_W-1:0] RANGE_TWO_FLOOR_RST = FLOOR_W'(26214);
    localparam logic [FLOOR_W-1:0] ZERO_FLOOR_RST      = FLOOR_W'(262);

    typedef enum logic [1:0] {
        CAL_R1,
        CAL_KINK,
        CAL_R2,
        CAL_R3
    } t_cal;

    typedef struct packed {
        logic               load;
        logic               eval;
        logic               mul;
        logic               latch_raw;
        logic               store_value;
        logic [RANGE_W-1:0] gain_range;
    } t_dp_cmd;

    typedef struct packed {
        logic [RANGE_W-1:0] pick;
    } t_dp_stat;

    typedef struct packed {
        logic [CH_W-1:0]    chan;
        logic               done;
        logic [RANGE_W-1:0] range;
        logic [CH_W-1:0]    sel;
    } t_out_info;

    function automatic logic [COEF_W-1:0] cal_coef(input t_cal sel);
        logic [COEF_W-1:0] c;
        case (sel)
            CAL_KINK: c = COEF_W'(137405536);
            CAL_R2:   c = COEF_W'(17129202);
            CAL_R3:   c = COEF_W'(17125847);
            default:  c = COEF_W'(16636489);
        endcase
        return c;
    endfunction

    function automatic logic [OFFS_W-1:0] cal_offs(input t_cal sel);
        logic [OFFS_W-1:0] o;
        case (sel)
            CAL_KINK: o = OFFS_W'(1297613);
            CAL_R2:   o = OFFS_W'(2148);
            CAL_R3:   o = OFFS_W'(129);
            default:  o = OFFS_W'(5078);
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/autorange_offset_calibrated_meter.sv =====
// Auto-ranging meter sequencer with offset subtraction and calibration, top level.
//
// Input stream: one word per ADC tick. tuser carries the requested channel
// (0 to 3, 4 or above selects the cleared input), tdata the signed Q5.18 sample.
// Output stream: one word per input word. tuser carries the driven input switch,
// gain range, done flag and channel; tdata the latest corrected value.
// Configuration: APB registers range_one_floor (0x0), range_two_floor (0x4),
// zero_floor (0x8), 23 bits each, readable; pready is tied high.
// Path: an accepted word is registered with its reciprocal-gain product, passes the
// evaluate state, on a measuring tick also the calibration-multiply state, and
// the finish state, which places its result in the output register. A new word is
// taken only once the previous one has been placed in the output register.
// The output register holds a finished word while the receiver stalls; the
// next word is still accepted and waits in the finish step until the slot frees.
// Reset (synchronous, active low): channel 0, range 1, select phase, cleared
// output valid, corrected value zero, registers to their defaults.
module autorange_offset_calibrated_meter #(
    parameter int SAMPLE_BITS = aocm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // channel
    input  logic [aocm_pkg::IN_USER_W-1:0]       i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // corrected_value
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    // input_select, gain_range, done_res, result_channel
    output logic [aocm_pkg::OUT_USER_W-1:0]      o_m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aocm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [aocm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [aocm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import aocm_pkg::*;

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [FLOOR_W-1:0]            r_range_one_floor;
    logic [FLOOR_W-1:0]            r_range_two_floor;
    logic [FLOOR_W-1:0]            r_zero_floor;

    logic                          w_wr;
    logic [1:0]                    w_reg_idx;
    t_dp_cmd                       w_cmd;
    t_dp_stat                      w_stat;
    t_out_info                     w_out;
    logic signed [SAMPLE_BITS-1:0] w_value;

    // register port
    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_one_floor <= RANGE_ONE_FLOOR_RST;
            r_range_two_floor <= RANGE_TWO_FLOOR_RST;
            r_zero_floor      <= ZERO_FLOOR_RST;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_RANGE_ONE_FLOOR: r_range_one_floor <= pwdata[FLOOR_W-1:0];
                REG_RANGE_TWO_FLOOR: r_range_two_floor <= pwdata[FLOOR_W-1:0];
                REG_ZERO_FLOOR:      r_zero_floor      <= pwdata[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_RANGE_ONE_FLOOR: prdata = APB_DATA_W'(r_range_one_floor);
            REG_RANGE_TWO_FLOOR: prdata = APB_DATA_W'(r_range_two_floor);
            REG_ZERO_FLOOR:      prdata = APB_DATA_W'(r_zero_floor);
            default:             prdata = '0;
        endcase
    end

    aocm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_channel   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (w_out),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    aocm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_sample          ($signed(i_s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_range_one_floor (r_range_one_floor),
        .i_range_two_floor (r_range_two_floor),
        .i_zero_floor      (r_zero_floor),
        .o_stat            (w_stat),
        .o_value           (w_value)
    );

    assign o_m_axis_tdata = DATA_W'($unsigned(w_value));
    assign o_m_axis_tuser = {w_out.chan, w_out.done, w_out.range, w_out.sel};

endmodule

// ===== rtl/aocm_datapath.sv =====
// datapath: gain division, range pick, offset difference, calibration and saturation
module aocm_datapath #(
    parameter int SAMPLE_BITS = aocm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  aocm_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [aocm_pkg::FLOOR_W-1:0]      i_range_one_floor,
    input  logic [aocm_pkg::FLOOR_W-1:0]      i_range_two_floor,
    input  logic [aocm_pkg::FLOOR_W-1:0]      i_zero_floor,
    output aocm_pkg::t_dp_stat                o_stat,
    output logic signed [SAMPLE_BITS-1:0]     o_value
);
    import aocm_pkg::*;

    localparam int PW   = SAMPLE_BITS + FRAC_SHIFT;
    localparam int CMPW = ((SAMPLE_BITS > FLOOR_W) ? SAMPLE_BITS : FLOOR_W) + 1;
    localparam int DW   = SAMPLE_BITS + 1;
    localparam int OPW  = ((DW > KINK_W + 1) ? DW : KINK_W + 1) + 1;
    localparam int CPW  = OPW + COEF_W + 1;
    localparam int RW   = CPW - FRAC_SHIFT;
    localparam int VW   = RW + 1;

    localparam logic signed [VW-1:0] SAT_HI =
        {{(VW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_LO =
        {{(VW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0]   r_sample;
    logic signed [PW-1:0]            r_prod;
    logic signed [SAMPLE_BITS-1:0]   r_raw;
    logic signed [OPW-1:0]           r_op;
    t_cal                            r_sel;
    logic signed [CPW-1:0]           r_cprod;
    logic signed [SAMPLE_BITS-1:0]   r_last;

    logic [RECIP_W-1:0]              w_recip;
    logic signed [SAMPLE_BITS+RECIP_W:0] w_prod;
    logic signed [PW-1:0]            w_prod_rnd;
    logic signed [SAMPLE_BITS-1:0]   w_t;
    logic                            w_gt_one;
    logic                            w_gt_two;
    logic signed [DW-1:0]            w_d;
    logic signed [OPW-1:0]           w_dk;
    logic                            w_kink;
    logic signed [OPW-1:0]           w_op;
    t_cal                            w_sel;
    logic [COEF_W-1:0]               w_coef;
    logic signed [CPW-1:0]           w_cprod;
    logic signed [CPW-1:0]           w_crnd;
    logic signed [RW-1:0]            w_cr;
    logic [OFFS_W-1:0]               w_offs;
    logic signed [VW-1:0]            w_v;
    logic signed [VW-1:0]            w_vf;
    logic signed [SAMPLE_BITS-1:0]   w_sat;

    // reciprocal gain on the incoming word
    always_comb begin
        case (i_cmd.gain_range)
            RANGE_X4:  w_recip = RECIP_R2;
            RANGE_X45: w_recip = RECIP_R3;
            default:   w_recip = '0;
        endcase
    end

    assign w_prod = i_sample * $signed({1'b0, w_recip});

    // gain-divided reading and range pick
    assign w_prod_rnd = r_prod + PW'(ROUND_HALF);
    assign w_t = (i_cmd.gain_range == RANGE_X1) ? r_sample
                                                : $signed(w_prod_rnd[FRAC_SHIFT +: SAMPLE_BITS]);

    assign w_gt_one = CMPW'(w_t) > CMPW'($signed({1'b0, i_range_one_floor}));
    assign w_gt_two = CMPW'(w_t) > CMPW'($signed({1'b0, i_range_two_floor}));

    always_comb begin
        if (w_gt_one) begin
            o_stat.pick = RANGE_X1;
        end else if (w_gt_two) begin
            o_stat.pick = RANGE_X4;
        end else begin
            o_stat.pick = RANGE_X45;
        end
    end

    // offset difference and calibration segment
    assign w_d    = DW'(r_raw) - DW'(w_t);
    assign w_dk   = OPW'(r_raw) - OPW'(w_t) - OPW'(KINK_AT);
    assign w_kink = (i_cmd.gain_range == RANGE_X1) && !w_dk[OPW-1];
    assign w_op   = w_kink ? w_dk : OPW'(w_d);

    always_comb begin
        case (i_cmd.gain_range)
            RANGE_X4:  w_sel = CAL_R2;
            RANGE_X45: w_sel = CAL_R3;
            default:   w_sel = w_kink ? CAL_KINK : CAL_R1;
        endcase
    end

    assign w_coef  = cal_coef(r_sel);
    assign w_cprod = r_op * $signed({1'b0, w_coef});

    // rounding, offset, zero floor and saturation
    assign w_crnd = r_cprod + CPW'(ROUND_HALF);
    assign w_cr   = w_crnd[CPW-1:FRAC_SHIFT];
    assign w_offs = cal_offs(r_sel);
    assign w_v    = VW'(w_cr) + VW'($signed({1'b0, w_offs}));
    assign w_vf   = ((r_sel == CAL_R3) && (w_v <= VW'($signed({1'b0, i_zero_floor}))))
                    ? '0 : w_v;

    always_comb begin
        if (w_vf > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_vf < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_vf[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_prod   <= PW'(w_prod);
        end
        if (i_cmd.eval) begin
            r_op  <= w_op;
            r_sel <= w_sel;
        end
        if (i_cmd.mul) begin
            r_cprod <= w_cprod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= '0;
            r_last <= '0;
        end else begin
            if (i_cmd.latch_raw) begin
                r_raw <= w_t;
            end
            if (i_cmd.store_value) begin
                r_last <= w_sat;
            end
        end
    end

    assign o_value = r_last;

endmodule

// ===== rtl/aocm_ctrl.sv =====
// controller: measurement phase sequencer, item handshake and result register
module aocm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [aocm_pkg::CH_W-1:0]      i_channel,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output aocm_pkg::t_out_info            o_out,
    output aocm_pkg::t_dp_cmd              o_cmd,
    input  aocm_pkg::t_dp_stat             i_stat
);
    import aocm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_CMUL = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [2:0] PH_SELECT = 3'd1;
    localparam logic [2:0] PH_PICK   = 3'd2;
    localparam logic [2:0] PH_WAIT   = 3'd3;
    localparam logic [2:0] PH_RUN    = 3'd4;
    localparam logic [2:0] PH_SETTLE = 3'd5;

    logic [1:0]         r_state, n_state;
    logic [2:0]         r_phase, n_phase;
    logic [CH_W-1:0]    r_chan, n_chan;
    logic [RANGE_W-1:0] r_range, n_range;
    logic [CH_W-1:0]    r_held, n_held;
    logic               r_done, n_done;
    logic               r_out_valid, n_out_valid;
    t_out_info          r_out;

    logic               w_changed;
    logic               w_out_free;
    logic               w_emit;

    assign w_changed  = (i_channel != r_chan);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_state == ST_FIN) && w_out_free;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_chan     = r_chan;
        n_range    = r_range;
        n_held     = r_held;
        n_done     = r_done;
        o_cmd      = '0;
        o_cmd.gain_range = r_range;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_chan     = i_channel;
                    n_state    = ST_EVAL;
                    if (w_changed) begin
                        o_cmd.gain_range = RANGE_X1;
                        n_phase          = PH_SELECT;
                        n_range          = RANGE_X1;
                    end
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_done     = 1'b0;
                n_state    = ST_FIN;
                unique case (r_phase)
                    PH_PICK: begin
                        if (i_stat.pick != r_range) begin
                            n_range = i_stat.pick;
                            n_phase = PH_SETTLE;
                        end else begin
                            o_cmd.latch_raw = 1'b1;
                            n_held          = CH_CLEARED;
                            n_phase         = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        n_phase = PH_RUN;
                    end
                    PH_RUN: begin
                        n_done  = 1'b1;
                        n_state = ST_CMUL;
                    end
                    PH_SETTLE: begin
                        n_phase = PH_PICK;
                    end
                    default: begin
                        // select the input, unused phase codes land here too
                        n_held  = (r_chan <= CH_LAST) ? r_chan : CH_CLEARED;
                        n_range = RANGE_X1;
                        n_phase = PH_PICK;
                    end
                endcase
            end
            ST_CMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.store_value = r_done;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SELECT;
            r_chan      <= '0;
            r_range     <= RANGE_X1;
            r_held      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_chan      <= n_chan;
            r_range     <= n_range;
            r_held      <= n_held;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.chan  <= r_chan;
            r_out.done  <= r_done;
            r_out.range <= r_range;
            r_out.sel   <= r_held;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/aocm_checker.sv =====
// port-level checker for the auto-ranging meter and its bind
module aocm_checker #(
    parameter int SAMPLE_BITS = aocm_pkg::SAMPLE_BITS_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    input logic [aocm_pkg::OUT_USER_W-1:0]      o_m_axis_tuser
);
    import aocm_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled output word changed");

    // one word in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a word is in work");

    // a finished measurement is always taken on the cleared input
    a_done_on_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[5]) |-> (o_m_axis_tuser[2:0] == CH_CLEARED))
        else $error("done without cleared input selected");

    // gain range never zero
    a_range_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[4:3] != 2'd0))
        else $error("gain range code zero");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind autorange_offset_calibrated_meter aocm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_aocm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
